// ----- rtl/core/dscs_pkg.sv -----
// Shared types, codes, constants and a helper function of the DDS serial command sequencer.
package dscs_pkg;

    localparam int TDATA_IN_W  = 40;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 8;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_SET_FREQ = 3'd1;
    localparam logic [2:0] OP_SET_AMPL = 3'd2;
    localparam logic [2:0] OP_OUT_ON   = 3'd3;
    localparam logic [2:0] OP_OUT_OFF  = 3'd4;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_WPREP  = 4'd1;
    localparam logic [3:0] PH_WSYNC  = 4'd2;
    localparam logic [3:0] PH_WBIT   = 4'd3;
    localparam logic [3:0] PH_WEND   = 4'd4;
    localparam logic [3:0] PH_ASTART = 4'd5;
    localparam logic [3:0] PH_ADOWN  = 4'd6;
    localparam logic [3:0] PH_AUPSET = 4'd7;
    localparam logic [3:0] PH_AUP    = 4'd8;
    localparam logic [3:0] PH_ALOCK  = 4'd9;

    localparam int PIN_CLK  = 0;
    localparam int PIN_SYNC = 1;
    localparam int PIN_DATA = 2;
    localparam int PIN_SEL  = 3;
    localparam logic [3:0] PINS_RESET = 4'b1011;

    localparam logic [15:0] WORD_RESET = 16'h2100;
    localparam logic [15:0] WORD_ON    = 16'h2000;
    localparam logic [15:0] WORD_FREQ  = 16'h4000;

    localparam int AMPLITUDE_STEPS = 64;
    localparam int PULSE_W         = 7;
    localparam logic [PULSE_W-1:0] PULSE_DOWN_LAST = PULSE_W'(AMPLITUDE_STEPS - 1);
    localparam logic [7:0] LEVEL_MAX = 8'd63;

    localparam int TUNING_W     = 28;
    localparam int FREQ_W       = 32;
    localparam int REF_CLOCK_HZ = 25000000;

    // The tuning value is floor(f * 2^73 / 390625 / 2^51), with the reciprocal
    // ceil(2^73 / 390625) split into two 32-bit halves; this is exact for any 32-bit f.
    localparam logic [FREQ_W-1:0] RECIP_LO    = 32'h88C2_30E8;
    localparam logic [FREQ_W-1:0] RECIP_HI    = 32'h0055_E63B;
    localparam int                RECIP_SHIFT = 51;
    localparam int                Q_LSB       = RECIP_SHIFT - FREQ_W;

    typedef struct packed {
        logic dropped;
        logic busy_res;
        logic amplitude_select;
        logic serial_data;
        logic frame_sync;
        logic serial_clock;
    } t_result;

    typedef struct packed {
        logic div_start;
        logic tuning_load;
    } t_eng_stat;

    function automatic logic [15:0] word_at(input logic [1:0] pos,
                                            input logic [TUNING_W-1:0] tuning);
        logic [15:0] w;
        case (pos)
            2'd0:    w = WORD_RESET;
            2'd1:    w = WORD_FREQ | {2'b00, tuning[13:0]};
            2'd2:    w = WORD_FREQ | {2'b00, tuning[27:14]};
            default: w = WORD_ON;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/dscs_divider.sv -----
// Reciprocal multiplier that turns a frequency into the 28-bit tuning value.
module dscs_divider
    import dscs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [FREQ_W-1:0]   i_frequency_hz,
    output logic                o_busy,
    output logic [TUNING_W-1:0] o_tuning
);

    logic                  r_busy;
    logic                  r_step;
    logic [FREQ_W-1:0]     r_freq;
    logic [FREQ_W-1:0]     r_part;
    logic [TUNING_W-1:0]   r_q;
    logic [FREQ_W-1:0]     mul_b;
    logic [2*FREQ_W-1:0]   product;
    logic [2*FREQ_W-1:0]   sum;

    // The first step multiplies by the low half, the second by the high half.
    assign mul_b   = r_step ? RECIP_HI : RECIP_LO;
    assign product = (2*FREQ_W)'(r_freq) * (2*FREQ_W)'(mul_b);
    assign sum     = product + {{FREQ_W{1'b0}}, r_part};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
            r_q    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 1'b0;
            r_freq <= i_frequency_hz;
        end else if (r_busy) begin
            if (r_step == 1'b0) begin
                r_part <= product[2*FREQ_W-1:FREQ_W];
                r_step <= 1'b1;
            end else begin
                r_q    <= sum[Q_LSB+TUNING_W-1:Q_LSB];
                r_step <= 1'b0;
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_tuning = r_q;

endmodule

// ----- rtl/core/dscs_engine.sv -----
// Sequencer state and pin logic; one tick is applied per accepted beat.
module dscs_engine
    import dscs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0]          i_operation,
    input  logic [7:0]          i_amplitude_level,
    input  logic [TUNING_W-1:0] i_tuning,
    output t_result             o_result,
    output t_eng_stat           o_stat
);

    logic [3:0]         r_phase, n_phase;
    logic [1:0]         r_wp, n_wp;
    logic [3:0]         r_bp, n_bp;
    logic [1:0]         r_tib, n_tib;
    logic [15:0]        r_sw, n_sw;
    logic [PULSE_W-1:0] r_pr, n_pr;
    logic [5:0]         r_ts, n_ts;
    logic [3:0]         r_pins, n_pins;
    logic               is_cmd;
    logic               busy;
    logic               dropped;

    assign is_cmd = i_operation inside {[OP_SET_FREQ:OP_OUT_OFF]};
    assign busy   = (r_phase != PH_IDLE);

    always_comb begin
        n_phase = r_phase;
        n_wp    = r_wp;
        n_bp    = r_bp;
        n_tib   = r_tib;
        n_sw    = r_sw;
        n_pr    = r_pr;
        n_ts    = r_ts;
        n_pins  = r_pins;
        dropped = 1'b0;
        o_stat  = '0;
        if (i_valid) begin
            dropped = is_cmd && busy;
            if (is_cmd && !busy) begin
                n_tib = 2'd0;
                n_bp  = 4'd15;
                case (i_operation)
                    OP_SET_FREQ: begin
                        o_stat.div_start = 1'b1;
                        n_wp    = 2'd0;
                        n_sw    = WORD_RESET;
                        n_phase = PH_WPREP;
                    end
                    OP_SET_AMPL: begin
                        n_ts    = (i_amplitude_level > LEVEL_MAX) ? LEVEL_MAX[5:0]
                                                                  : i_amplitude_level[5:0];
                        n_phase = PH_ASTART;
                    end
                    default: begin
                        n_wp    = 2'd3;
                        n_sw    = (i_operation == OP_OUT_ON) ? WORD_ON : WORD_RESET;
                        n_phase = PH_WPREP;
                    end
                endcase
            end
            case (n_phase)
                PH_IDLE: begin
                end
                PH_WPREP: begin
                    n_pins[PIN_CLK]  = 1'b1;
                    n_pins[PIN_SYNC] = 1'b1;
                    n_phase = PH_WSYNC;
                end
                PH_WSYNC: begin
                    n_pins[PIN_SYNC] = 1'b0;
                    n_bp    = 4'd15;
                    n_tib   = 2'd0;
                    n_phase = PH_WBIT;
                end
                PH_WBIT: begin
                    if (n_tib == 2'd0) begin
                        n_pins[PIN_DATA] = n_sw[n_bp];
                        n_tib = 2'd1;
                    end else if (n_tib == 2'd1) begin
                        n_pins[PIN_CLK] = 1'b0;
                        n_tib = 2'd2;
                    end else begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_tib = 2'd0;
                        if (n_bp == 4'd0) begin
                            n_phase = PH_WEND;
                        end else begin
                            n_bp = n_bp - 1'b1;
                        end
                    end
                end
                PH_WEND: begin
                    n_pins[PIN_SYNC] = 1'b1;
                    n_bp = 4'd15;
                    if (n_wp == 2'd3) begin
                        n_wp    = 2'd0;
                        n_phase = PH_IDLE;
                    end else begin
                        o_stat.tuning_load = 1'b1;
                        n_wp    = n_wp + 1'b1;
                        n_sw    = word_at(n_wp, i_tuning);
                        n_phase = PH_WPREP;
                    end
                end
                PH_ASTART: begin
                    n_pins[PIN_SYNC] = 1'b1;
                    n_pins[PIN_SEL]  = 1'b0;
                    n_pins[PIN_DATA] = 1'b0;
                    n_pr    = PULSE_DOWN_LAST;
                    n_tib   = 2'd0;
                    n_phase = PH_ADOWN;
                end
                PH_ADOWN, PH_AUP: begin
                    if (n_tib == 2'd0) begin
                        n_pins[PIN_CLK] = 1'b1;
                        n_tib = 2'd1;
                    end else begin
                        n_pins[PIN_CLK] = 1'b0;
                        n_tib = 2'd0;
                        if (n_pr == '0) begin
                            n_phase = (n_phase == PH_ADOWN) ? PH_AUPSET : PH_ALOCK;
                        end else begin
                            n_pr = n_pr - 1'b1;
                        end
                    end
                end
                PH_AUPSET: begin
                    n_pins[PIN_DATA] = 1'b1;
                    n_tib = 2'd0;
                    if (n_ts == 6'd0) begin
                        n_phase = PH_ALOCK;
                    end else begin
                        n_pr    = PULSE_W'(n_ts - 1'b1);
                        n_phase = PH_AUP;
                    end
                end
                PH_ALOCK: begin
                    n_pins[PIN_SEL]  = 1'b1;
                    n_pins[PIN_CLK]  = 1'b1;
                    n_pins[PIN_DATA] = 1'b0;
                    n_pr    = '0;
                    n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wp    <= '0;
            r_bp    <= 4'd15;
            r_tib   <= '0;
            r_sw    <= '0;
            r_pr    <= '0;
            r_ts    <= '0;
            r_pins  <= PINS_RESET;
        end else begin
            r_phase <= n_phase;
            r_wp    <= n_wp;
            r_bp    <= n_bp;
            r_tib   <= n_tib;
            r_sw    <= n_sw;
            r_pr    <= n_pr;
            r_ts    <= n_ts;
            r_pins  <= n_pins;
        end
    end

    assign o_result.serial_clock     = n_pins[PIN_CLK];
    assign o_result.frame_sync       = n_pins[PIN_SYNC];
    assign o_result.serial_data      = n_pins[PIN_DATA];
    assign o_result.amplitude_select = n_pins[PIN_SEL];
    assign o_result.busy_res         = (n_phase != PH_IDLE);
    assign o_result.dropped          = dropped;

endmodule

// ----- rtl/core/dscs_out_buf.sv -----
// Output register with a skid entry; the input side waits only while the skid entry is full.
module dscs_out_buf
    import dscs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_in_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out   <= i_result;
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_skid   <= i_result;
            r_skid_v <= 1'b1;
        end
    end

    assign o_in_ready = !r_skid_v;
    assign o_valid    = r_out_v;
    assign o_result   = r_out;

endmodule

// ----- rtl/core/dds_serial_command_sequencer.sv -----
// Top level of the DDS serial command sequencer: one pin-phase tick per input beat.
// The result of a beat is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one beat per cycle while s_axis_tready is high; the sequencer state updates in the cycle of the beat.
// The tuning multiplier finishes well within the 50 ticks before the value is sent.
// Reset (synchronous, active low) returns the sequencer to idle with the pins idle.
module dds_serial_command_sequencer
    import dscs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: frequency_hz[31:0], amplitude_level[39:32].
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    // Fields from bit 0: operation[2:0].
    input  logic [TUSER_IN_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: serial_clock, frame_sync, serial_data, amplitude_select,
    // busy_res, dropped.
    output logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    logic                accept;
    logic [2:0]          operation;
    logic [FREQ_W-1:0]   frequency_hz;
    logic [7:0]          amplitude_level;
    logic [TUNING_W-1:0] tuning;
    logic                div_busy;
    t_result             eng_result;
    t_result             out_result;
    t_eng_stat           eng_stat;

    assign operation       = s_axis_tuser;
    assign frequency_hz    = s_axis_tdata[31:0];
    assign amplitude_level = s_axis_tdata[39:32];
    assign accept          = s_axis_tvalid && s_axis_tready;

    dscs_divider u_divider (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (eng_stat.div_start),
        .i_frequency_hz (frequency_hz),
        .o_busy         (div_busy),
        .o_tuning       (tuning)
    );

    dscs_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (accept),
        .i_operation       (operation),
        .i_amplitude_level (amplitude_level),
        .i_tuning          (tuning),
        .o_result          (eng_result),
        .o_stat            (eng_stat)
    );

    dscs_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_result   (eng_result),
        .o_in_ready (s_axis_tready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata = {2'b00, out_result};

`ifndef SYNTHESIS
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.tuning_load |-> !div_busy)
        else $error("Tuning value used while the divider is still running.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.div_start |-> !div_busy)
        else $error("Divider restarted while busy.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Skid entry full while the output register is empty.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("Accepted beat did not reach the output register.");
`endif

endmodule
